// ===== rtl/qpc_pkg.sv =====
package qpc_pkg;

  localparam logic [7:0] EqChar = 8'h3D;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam int unsigned MaxBytes = 3;
  localparam int unsigned CountW   = $clog2(MaxBytes + 1);

  // group of result bytes produced by one input beat, oldest in slot 0
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    logic                     last;
  } qpc_result_t;

  function automatic logic [7:0] hex_upper(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h37 + {4'd0, v};
    end
    return r;
  endfunction

  function automatic logic hex_valid(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // nibble value of a hex digit; only meaningful when hex_valid holds
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] r;
    if (c <= 8'h39) begin
      r = c[3:0];
    end else begin
      r = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

// ===== rtl/qpc_stream_if.sv =====
interface qpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       msg_end;

  modport source (output valid, output data_byte, output msg_end, input ready);
  modport sink (input valid, input data_byte, input msg_end, output ready);
endinterface

interface qpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_final;

  modport source (output valid, output out_byte, output out_final, input ready);
  modport sink (input valid, input out_byte, input out_final, output ready);
endinterface

// ===== rtl/qpc_convert.sv =====
module qpc_convert
  import qpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        msg_end_i,
  output qpc_result_t result_o
);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhEq   = 2'd1;
  localparam logic [1:0] PhHeld = 2'd2;

  logic       mode_q, mode_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;

  always_comb begin
    result_o      = '0;
    result_o.last = msg_end_i;
    mode_d        = mode_q;
    phase_d       = phase_q;
    held_d        = held_q;
    if (cfg_we_i) begin
      // a mode write drops any partial escape
      mode_d  = cfg_wdata_i;
      phase_d = PhIdle;
      held_d  = '0;
    end else if (accept_i) begin
      if (mode_q == ModeEncode) begin
        if (data_byte_i >= 8'h80 || data_byte_i < 8'h20 || data_byte_i == EqChar) begin
          result_o.bytes[0] = EqChar;
          result_o.bytes[1] = hex_upper(data_byte_i[7:4]);
          result_o.bytes[2] = hex_upper(data_byte_i[3:0]);
          result_o.count    = CountW'(3);
        end else begin
          result_o.bytes[0] = data_byte_i;
          result_o.count    = CountW'(1);
        end
      end else begin
        unique case (phase_q)
          PhEq: begin
            if (msg_end_i) begin
              result_o.bytes[0] = EqChar;
              result_o.bytes[1] = data_byte_i;
              result_o.count    = CountW'(2);
              phase_d           = PhIdle;
              held_d            = '0;
            end else begin
              held_d  = data_byte_i;
              phase_d = PhHeld;
            end
          end
          PhHeld: begin
            if (hex_valid(held_q) && hex_valid(data_byte_i)) begin
              result_o.bytes[0] = {hex_nibble(held_q), hex_nibble(data_byte_i)};
              result_o.count    = CountW'(1);
            end else begin
              result_o.bytes[0] = EqChar;
              result_o.bytes[1] = held_q;
              result_o.bytes[2] = data_byte_i;
              result_o.count    = CountW'(3);
            end
            phase_d = PhIdle;
            held_d  = '0;
          end
          default: begin
            // idle, and the unused code behaves as idle
            phase_d = PhIdle;
            if (data_byte_i == EqChar && !msg_end_i) begin
              phase_d = PhEq;
            end else begin
              result_o.bytes[0] = data_byte_i;
              result_o.count    = CountW'(1);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeEncode;
      phase_q <= PhIdle;
      held_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== rtl/qpc_emitter.sv =====
module qpc_emitter
  import qpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  qpc_result_t result_i,
  input  logic        out_ready_i,
  output logic        load_ready_o,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        out_final_o
);

  logic [MaxBytes-1:0][7:0] buf_q, buf_d;
  logic [CountW-1:0]        count_q, count_d;
  logic                     last_q, last_d;
  logic                     pop;

  assign out_valid_o  = (count_q != '0);
  assign pop          = out_valid_o && out_ready_i;
  // room for a new beat once the last buffered byte leaves this cycle
  assign load_ready_o = (count_q == '0) || (count_q == CountW'(1) && out_ready_i);
  assign out_byte_o   = buf_q[0];
  assign out_final_o  = last_q && (count_q == CountW'(1));

  always_comb begin
    buf_d   = buf_q;
    count_d = count_q;
    last_d  = last_q;
    if (load_i) begin
      buf_d   = result_i.bytes;
      count_d = result_i.count;
      last_d  = result_i.last;
    end else if (pop) begin
      for (int i = 0; i < MaxBytes - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      buf_d[MaxBytes-1] = '0;
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      last_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

// ===== rtl/quoted_printable_codec.sv =====
// Quoted-printable codec for a byte stream.
// in_if carries one message byte per beat with msg_end on its last byte;
// out_if carries the converted bytes with out_final on the last byte that
// a message produces. cfg_we_i/cfg_wdata_i write the mode bit (0 encode,
// 1 decode); the user must write it only while the stream is idle, which
// the block does not enforce. A write drops any partial escape. A beat's
// first byte appears on out_if the cycle after it. Throughput: one input
// beat per cycle while each beat yields at most one byte and out_if is
// ready. A beat that yields three bytes (an escape in encode mode, or a
// broken escape in decode mode) holds in_if off while the three-byte
// output buffer drains at one byte per cycle; occupancy and out_if.ready
// set the rate. Beats that yield nothing (an escape being gathered) are
// taken every cycle once the buffer has room. When out_if stalls the
// buffer holds its bytes and in_if.ready drops once a new beat would not
// fit. Reset clears the mode to encode, the escape state and the buffer.
module quoted_printable_codec
  import qpc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  qpc_in_if.sink    in_if,
  qpc_out_if.source out_if
);

  qpc_result_t result;
  logic        accept;
  logic        load_ready;

  assign in_if.ready = load_ready;
  assign accept      = in_if.valid && load_ready;

  qpc_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .data_byte_i (in_if.data_byte),
    .msg_end_i   (in_if.msg_end),
    .result_o    (result)
  );

  qpc_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .result_i     (result),
    .out_ready_i  (out_if.ready),
    .load_ready_o (load_ready),
    .out_valid_o  (out_if.valid),
    .out_byte_o   (out_if.out_byte),
    .out_final_o  (out_if.out_final)
  );

endmodule
